### sv/qrs_pkg.sv
// qrs_pkg: shared constants, widths and status codes for the quadratic root solver.
// No dependencies.
package qrs_pkg;
   localparam int COEF_WIDTH_DEF    = 16;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int DISC_WIDTH        = 34;
   localparam int ROOT_WIDTH        = 25;

   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_ONE   = 2'd1,
      ST_TWO   = 2'd2,
      ST_DEGEN = 2'd3
   } status_type;
endpackage

### sv/qrs_if.sv
// qrs_req_if / qrs_rsp_if: valid/ready channels for coefficient and result beats.
// Depends on qrs_pkg.
interface qrs_req_if import qrs_pkg::*; #(parameter int CW = COEF_WIDTH_DEF);
   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] coef_a;
   logic signed [CW-1:0] coef_b;
   logic signed [CW-1:0] coef_c;
   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_rsp_if import qrs_pkg::*;;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   root_status;
   logic signed [DISC_WIDTH-1:0] discriminant;
   logic signed [ROOT_WIDTH-1:0] root_plus;
   logic signed [ROOT_WIDTH-1:0] root_minus;
   modport source (output valid, root_status, discriminant, root_plus, root_minus,
                   input ready);
   modport sink   (input valid, root_status, discriminant, root_plus, root_minus,
                   output ready);
endinterface

### sv/qrs_sqrt_stage.sv
// qrs_sqrt_stage: one registered stage of the digit-by-digit square root.
// Depends on qrs_pkg; retires STEPS result bits per stage.
module qrs_sqrt_stage import qrs_pkg::*; #(
   parameter int RW    = 40,
   parameter int STEPS = 4
) (
   input  logic          clock,
   input  logic          en,
   input  logic [2*RW-1:0] rad_i,
   input  logic [RW+1:0] rem_i,
   input  logic [RW-1:0] root_i,
   output logic [2*RW-1:0] rad_o,
   output logic [RW+1:0] rem_o,
   output logic [RW-1:0] root_o
);
   logic [2*RW-1:0] rad_in;
   logic [RW+1:0]   rem_in;
   logic [RW-1:0]   root_in;
   logic [2*RW-1:0] rad_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;

   always_comb begin
      logic [RW+1:0] trial;
      rad_in  = rad_i;
      rem_in  = rem_i;
      root_in = root_i;
      for (int k = 0; k < STEPS; k++) begin
         rem_in = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
         rad_in = {rad_in[2*RW-3:0], 2'b00};
         trial  = {root_in, 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_in[RW-2:0], 1'b1};
         end else begin
            root_in = {root_in[RW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
endmodule

### sv/qrs_div_stage.sv
// qrs_div_stage: one registered stage of two parallel restoring dividers.
// Depends on qrs_pkg; retires STEPS quotient bits per lane per stage.
module qrs_div_stage import qrs_pkg::*; #(
   parameter int NW    = 42,
   parameter int DW    = 18,
   parameter int STEPS = 6
) (
   input  logic          clock,
   input  logic          en,
   input  logic [DW-1:0] den_i,
   input  logic [NW-1:0] num_i [2],
   input  logic [DW:0]   rem_i [2],
   output logic [NW-1:0] num_o [2],
   output logic [DW:0]   rem_o [2]
);
   logic [NW-1:0] num_in [2];
   logic [DW:0]   rem_in [2];
   logic [NW-1:0] num_ff [2];
   logic [DW:0]   rem_ff [2];

   always_comb begin
      logic [DW+1:0] sh;
      for (int l = 0; l < 2; l++) begin
         num_in[l] = num_i[l];
         rem_in[l] = rem_i[l];
         for (int k = 0; k < STEPS; k++) begin
            sh = {rem_in[l], num_in[l][NW-1]};
            num_in[l] = {num_in[l][NW-2:0], 1'b0};
            if (sh >= {2'b00, den_i}) begin
               sh = sh - {2'b00, den_i};
               num_in[l][0] = 1'b1;
            end
            rem_in[l] = sh[DW:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign num_o = num_ff;
   assign rem_o = rem_ff;
endmodule

### sv/quadratic_real_root_solver_core.sv
// Quadratic real-root solver. One coefficient beat in, one result beat out, one
// beat per cycle sustained while results are taken. The pipeline is a products
// stage and a discriminant stage, ceil(RW/4) square-root stages of four digits
// each, one numerator stage, ceil(NW/6) divider stages of six bits each, and one
// output register. The whole pipe advances when the output register is empty or
// taken, so a stalled result holds every stage.
module quadratic_real_root_solver_core import qrs_pkg::*; #(
   parameter int COEF_WIDTH    = COEF_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   qrs_req_if.sink  req,
   qrs_rsp_if.source rsp
);
   localparam int CW   = COEF_WIDTH;
   localparam int FB   = FRACTION_BITS;
   localparam int PW   = 2*CW + 3;             // discriminant width
   localparam int RW   = CW + 1 + FB;          // sqrt result width
   localparam int SQ_S = 4;
   localparam int SQ_N = (RW + SQ_S - 1) / SQ_S;
   localparam int RWP  = SQ_N * SQ_S;
   localparam int NW   = CW + FB + 3;          // numerator magnitude width
   localparam int DW   = CW + 1;               // |2a| width
   localparam int DV_S = 6;
   localparam int DV_N = (NW + DV_S - 1) / DV_S;
   localparam int NWP  = DV_N * DV_S;
   localparam int NPIPE = 2 + SQ_N + 1 + DV_N;

   typedef struct packed {
      logic [1:0]           status;
      logic signed [PW-1:0] disc;
      logic                 den_neg;
      logic [DW-1:0]        den_mag;
   } side_type;

   logic adv;
   logic [NPIPE-1:0] vld_ff;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[NPIPE-2:0], req.valid};
         out_vld_ff <= vld_ff[NPIPE-1];
      end
   end

   // stage 1: products
   logic signed [2*CW-1:0] bb_ff, ac_ff;
   logic signed [CW-1:0]   a1_ff, b1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         bb_ff <= req.coef_b * req.coef_b;
         ac_ff <= req.coef_a * req.coef_c;
         a1_ff <= req.coef_a;
         b1_ff <= req.coef_b;
      end
   end

   // stage 2: discriminant and classification
   logic signed [PW-1:0] disc_in;
   side_type side2_in, side2_ff;
   logic signed [CW-1:0] b2_ff;
   always_comb begin
      disc_in = PW'(bb_ff) - (PW'(ac_ff) <<< 2);
      side2_in.disc    = disc_in;
      side2_in.den_neg = a1_ff[CW-1];
      side2_in.den_mag = a1_ff[CW-1] ? DW'(-{a1_ff[CW-1], a1_ff}) << 1
                                     : DW'({a1_ff[CW-1], a1_ff}) << 1;
      priority if (a1_ff == '0)        side2_in.status = ST_DEGEN;
      else if (disc_in < 0)            side2_in.status = ST_NONE;
      else if (disc_in == '0)          side2_in.status = ST_ONE;
      else                             side2_in.status = ST_TWO;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
         b2_ff    <= b1_ff;
      end
   end

   // square root pipeline
   logic [2*RWP-1:0] rad [SQ_N+1];
   logic [RWP+1:0]   srem [SQ_N+1];
   logic [RWP-1:0]   sroot [SQ_N+1];
   side_type         sside [SQ_N+1];
   logic signed [CW-1:0] sb [SQ_N+1];
   assign rad[0]   = side2_ff.disc < 0 ? '0 : (2*RWP)'(side2_ff.disc) << (2*FB);
   assign srem[0]  = '0;
   assign sroot[0] = '0;
   assign sside[0] = side2_ff;
   assign sb[0]    = b2_ff;

   for (genvar g = 0; g < SQ_N; g++) begin : g_sq
      side_type sd_ff;
      logic signed [CW-1:0] b_ff;
      qrs_sqrt_stage #(.RW(RWP), .STEPS(SQ_S)) u_sq (
         .clock, .en(adv),
         .rad_i(rad[g]), .rem_i(srem[g]), .root_i(sroot[g]),
         .rad_o(rad[g+1]), .rem_o(srem[g+1]), .root_o(sroot[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            sd_ff <= sside[g];
            b_ff  <= sb[g];
         end
      end
      assign sside[g+1] = sd_ff;
      assign sb[g+1]    = b_ff;
   end

   // numerator stage: signed numerators, sign of quotient, magnitudes
   logic signed [NW:0] nb_s, np_s, nm_s;
   logic [NWP-1:0] nmag_ff [2];
   logic           qneg_ff [2];
   side_type       nside_ff;
   always_comb begin
      nb_s = -((NW+1)'(sb[SQ_N]) <<< FB);
      np_s = nb_s + (NW+1)'({1'b0, sroot[SQ_N]});
      nm_s = nb_s - (NW+1)'({1'b0, sroot[SQ_N]});
      if (sside[SQ_N].status == ST_ONE) begin
         np_s = nb_s;
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         nside_ff   <= sside[SQ_N];
         nmag_ff[0] <= NWP'(np_s[NW] ? -np_s : np_s);
         nmag_ff[1] <= NWP'(nm_s[NW] ? -nm_s : nm_s);
         qneg_ff[0] <= np_s[NW] ^ sside[SQ_N].den_neg;
         qneg_ff[1] <= nm_s[NW] ^ sside[SQ_N].den_neg;
      end
   end

   // divider pipeline
   logic [NWP-1:0] dnum [DV_N+1][2];
   logic [DW:0]    drem [DV_N+1][2];
   side_type       dside [DV_N+1];
   logic           dneg [DV_N+1][2];
   assign dnum[0]  = nmag_ff;
   assign drem[0]  = '{'0, '0};
   assign dside[0] = nside_ff;
   assign dneg[0]  = qneg_ff;

   for (genvar g = 0; g < DV_N; g++) begin : g_dv
      side_type sd_ff;
      logic     ng_ff [2];
      qrs_div_stage #(.NW(NWP), .DW(DW), .STEPS(DV_S)) u_dv (
         .clock, .en(adv), .den_i(dside[g].den_mag),
         .num_i(dnum[g]), .rem_i(drem[g]),
         .num_o(dnum[g+1]), .rem_o(drem[g+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            sd_ff <= dside[g];
            ng_ff <= dneg[g];
         end
      end
      assign dside[g+1] = sd_ff;
      assign dneg[g+1]  = ng_ff;
   end

   // output register with saturation
   function automatic logic signed [ROOT_WIDTH-1:0] sat_root(
      input logic [NWP-1:0] mag, input logic neg);
      logic [NWP:0] hi;
      hi = (NWP+1)'({1'b0, {(ROOT_WIDTH-1){1'b1}}});
      if (neg) begin
         if ({1'b0, mag} > hi + 1) sat_root = {1'b1, {(ROOT_WIDTH-1){1'b0}}};
         else sat_root = ROOT_WIDTH'(-{1'b0, mag});
      end else begin
         if ({1'b0, mag} > hi) sat_root = {1'b0, {(ROOT_WIDTH-1){1'b1}}};
         else sat_root = ROOT_WIDTH'(mag);
      end
   endfunction

   function automatic logic signed [DISC_WIDTH-1:0] sat_disc(
      input logic signed [PW-1:0] d);
      localparam int XW = (PW > DISC_WIDTH) ? PW : DISC_WIDTH;
      logic signed [XW-1:0] x, hi, lo;
      x  = XW'(d);
      hi = XW'({1'b0, {(DISC_WIDTH-1){1'b1}}});
      lo = -hi - 1;
      if (x > hi)      sat_disc = DISC_WIDTH'(hi);
      else if (x < lo) sat_disc = DISC_WIDTH'(lo);
      else             sat_disc = DISC_WIDTH'(x);
   endfunction

   logic [1:0]                   st_ff;
   logic signed [DISC_WIDTH-1:0] disc_ff;
   logic signed [ROOT_WIDTH-1:0] rp_ff, rm_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= dside[DV_N].status;
         disc_ff <= sat_disc(dside[DV_N].disc);
         rp_ff   <= (dside[DV_N].status == ST_ONE || dside[DV_N].status == ST_TWO)
                    ? sat_root(dnum[DV_N][0], dneg[DV_N][0]) : '0;
         rm_ff   <= (dside[DV_N].status == ST_TWO)
                    ? sat_root(dnum[DV_N][1], dneg[DV_N][1]) : '0;
      end
   end

   assign rsp.valid        = out_vld_ff;
   assign rsp.root_status  = st_ff;
   assign rsp.discriminant = disc_ff;
   assign rsp.root_plus    = rp_ff;
   assign rsp.root_minus   = rm_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.root_plus))
      else $error("result dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready) else $error("pipe stalled with empty output");
   a_unused: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.root_status == ST_NONE || rsp.root_status == ST_DEGEN)
      |-> rsp.root_plus == '0 && rsp.root_minus == '0)
      else $error("unused root nonzero");
`endif
endmodule
